>>> sv/sled_pkg.sv
// shared types and constants of the string literal escape decoder
package sled_pkg;

    localparam int CP_WIDTH    = 21;
    localparam int CHAR_WIDTH  = 32;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [1:0] KIND_CHAR = 2'd0;
    localparam logic [1:0] KIND_OK   = 2'd1;
    localparam logic [1:0] KIND_BAD  = 2'd2;

    typedef struct packed {
        logic [1:0]            nchars;
        logic [CHAR_WIDTH-1:0] ch0;
        logic [CHAR_WIDTH-1:0] ch1;
        logic                  has_end;
        logic                  end_bad;
    } bundle_t;

endpackage

>>> sv/sled_front.sv
// front end: takes code points, tracks escape state and builds result bundles
module sled_front
    import sled_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  logic [CP_WIDTH-1:0] code_point,
    input  logic                token_end,
    input  logic                queue_full,
    output logic                push,
    output bundle_t             push_data
);

    typedef enum logic [2:0] {
        PH_START,
        PH_BODY,
        PH_ESC,
        PH_HEX,
        PH_DEC,
        PH_OCT,
        PH_UNI,
        PH_AFTER
    } phase_t;

    localparam logic [CP_WIDTH-1:0] CH_QUOTE  = 21'h22;
    localparam logic [CP_WIDTH-1:0] CH_BSLASH = 21'h5C;
    localparam logic [CP_WIDTH-1:0] CH_CR     = 21'h0D;
    localparam logic [CP_WIDTH-1:0] CH_LF     = 21'h0A;
    localparam logic [CP_WIDTH-1:0] CH_ZERO   = 21'h30;
    localparam logic [CP_WIDTH-1:0] CH_SEVEN  = 21'h37;
    localparam logic [CP_WIDTH-1:0] CH_NINE   = 21'h39;
    localparam logic [CP_WIDTH-1:0] CH_A_UP   = 21'h41;
    localparam logic [CP_WIDTH-1:0] CH_F_UP   = 21'h46;
    localparam logic [CP_WIDTH-1:0] CH_A_LO   = 21'h61;
    localparam logic [CP_WIDTH-1:0] CH_F_LO   = 21'h66;
    localparam logic [CP_WIDTH-1:0] CH_X_UP   = 21'h58;
    localparam logic [CP_WIDTH-1:0] CH_X_LO   = 21'h78;
    localparam logic [CP_WIDTH-1:0] CH_D_UP   = 21'h44;
    localparam logic [CP_WIDTH-1:0] CH_D_LO   = 21'h64;
    localparam logic [CP_WIDTH-1:0] CH_U_UP   = 21'h55;
    localparam logic [CP_WIDTH-1:0] CH_U_LO   = 21'h75;
    localparam logic [CP_WIDTH-1:0] CH_B_LO   = 21'h62;
    localparam logic [CP_WIDTH-1:0] CH_N_LO   = 21'h6E;
    localparam logic [CP_WIDTH-1:0] CH_R_LO   = 21'h72;
    localparam logic [CP_WIDTH-1:0] CH_T_LO   = 21'h74;
    localparam logic [CP_WIDTH-1:0] CH_V_LO   = 21'h76;

    localparam logic [3:0] UNI_SHORT = 4'd4;
    localparam logic [3:0] UNI_LONG  = 4'd8;

    phase_t                 phase_reg, phase_next;
    logic [VALUE_WIDTH-1:0] acc_reg, acc_next;
    logic [3:0]             left_reg, left_next;
    logic                   inv_reg, inv_next;

    logic                   accept;
    logic                   is_hex;
    logic [3:0]             hex_val;
    logic                   is_dec;
    logic                   is_oct;
    logic                   do_body;
    logic [VALUE_WIDTH-1:0] acc_x16, acc_x10, acc_x8;
    bundle_t                bnd;

    function automatic bundle_t add_char(bundle_t b, logic [CHAR_WIDTH-1:0] v);
        bundle_t r;
        r = b;
        if (b.nchars == 2'd0)
        begin
            r.ch0 = v;
        end
        else
        begin
            r.ch1 = v;
        end
        r.nchars = b.nchars + 2'd1;
        return r;
    endfunction

    function automatic logic [CHAR_WIDTH-1:0] esc_map(logic [CP_WIDTH-1:0] c);
        logic [CHAR_WIDTH-1:0] v;
        case (c)
            CH_A_LO: v = 32'd7;
            CH_B_LO: v = 32'd8;
            CH_F_LO: v = 32'd12;
            CH_N_LO: v = 32'd10;
            CH_R_LO: v = 32'd13;
            CH_T_LO: v = 32'd9;
            CH_V_LO: v = 32'd11;
            default: v = CHAR_WIDTH'(c);
        endcase
        return v;
    endfunction

    assign item_stall = queue_full;
    assign accept     = item_valid && !queue_full;

    always_comb
    begin
        is_hex  = 1'b0;
        hex_val = code_point[3:0];
        if (code_point >= CH_ZERO && code_point <= CH_NINE)
        begin
            is_hex = 1'b1;
        end
        else if ((code_point >= CH_A_UP && code_point <= CH_F_UP) ||
                 (code_point >= CH_A_LO && code_point <= CH_F_LO))
        begin
            is_hex  = 1'b1;
            hex_val = code_point[3:0] + 4'd9;
        end
    end

    assign is_dec  = code_point >= CH_ZERO && code_point <= CH_NINE;
    assign is_oct  = code_point >= CH_ZERO && code_point <= CH_SEVEN;
    assign acc_x16 = acc_reg << 4;
    assign acc_x8  = acc_reg << 3;
    assign acc_x10 = (acc_reg << 3) + (acc_reg << 1);

    always_comb
    begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        left_next  = left_reg;
        inv_next   = inv_reg;
        bnd        = '0;
        do_body    = 1'b0;
        case (phase_reg)
            PH_BODY:
            begin
                do_body = 1'b1;
            end
            PH_ESC:
            begin
                acc_next = '0;
                if (code_point == CH_X_LO || code_point == CH_X_UP)
                begin
                    phase_next = PH_HEX;
                end
                else if (code_point == CH_D_LO || code_point == CH_D_UP)
                begin
                    phase_next = PH_DEC;
                end
                else if (is_oct)
                begin
                    acc_next   = VALUE_WIDTH'(code_point[2:0]);
                    phase_next = PH_OCT;
                end
                else if (code_point == CH_U_LO)
                begin
                    left_next  = UNI_SHORT;
                    phase_next = PH_UNI;
                end
                else if (code_point == CH_U_UP)
                begin
                    left_next  = UNI_LONG;
                    phase_next = PH_UNI;
                end
                else
                begin
                    bnd        = add_char(bnd, esc_map(code_point));
                    phase_next = PH_BODY;
                end
            end
            PH_HEX:
            begin
                if (is_hex)
                begin
                    acc_next = acc_x16 + VALUE_WIDTH'(hex_val);
                end
                else
                begin
                    bnd        = add_char(bnd, CHAR_WIDTH'(acc_reg));
                    acc_next   = '0;
                    phase_next = PH_BODY;
                    do_body    = 1'b1;
                end
            end
            PH_DEC:
            begin
                if (is_dec)
                begin
                    acc_next = acc_x10 + VALUE_WIDTH'(code_point[3:0]);
                end
                else
                begin
                    bnd        = add_char(bnd, CHAR_WIDTH'(acc_reg));
                    acc_next   = '0;
                    phase_next = PH_BODY;
                    do_body    = 1'b1;
                end
            end
            PH_OCT:
            begin
                if (is_oct)
                begin
                    acc_next = acc_x8 + VALUE_WIDTH'(code_point[2:0]);
                end
                else
                begin
                    bnd        = add_char(bnd, CHAR_WIDTH'(acc_reg));
                    acc_next   = '0;
                    phase_next = PH_BODY;
                    do_body    = 1'b1;
                end
            end
            PH_UNI:
            begin
                if (is_hex)
                begin
                    acc_next = acc_x16 + VALUE_WIDTH'(hex_val);
                end
                left_next = left_reg - 4'd1;
                if (left_next == 4'd0)
                begin
                    bnd        = add_char(bnd, CHAR_WIDTH'(acc_next));
                    acc_next   = '0;
                    phase_next = PH_BODY;
                end
            end
            PH_AFTER:
            begin
                inv_next = 1'b1;
            end
            default:
            begin
                phase_next = PH_BODY;
                if (code_point != CH_QUOTE)
                begin
                    do_body = 1'b1;
                end
            end
        endcase

        if (do_body)
        begin
            if (code_point == CH_QUOTE)
            begin
                phase_next = PH_AFTER;
            end
            else if (code_point == CH_CR || code_point == CH_LF)
            begin
                inv_next   = 1'b1;
                phase_next = PH_AFTER;
            end
            else if (code_point == CH_BSLASH)
            begin
                phase_next = PH_ESC;
            end
            else
            begin
                bnd = add_char(bnd, CHAR_WIDTH'(code_point));
            end
        end

        if (token_end)
        begin
            if (phase_next == PH_ESC)
            begin
                bnd = add_char(bnd, '0);
            end
            else if (phase_next == PH_HEX || phase_next == PH_DEC || phase_next == PH_OCT)
            begin
                bnd = add_char(bnd, CHAR_WIDTH'(acc_next));
            end
            else if (phase_next == PH_UNI && left_next != 4'd0)
            begin
                inv_next = 1'b1;
            end
            bnd.has_end = 1'b1;
            bnd.end_bad = inv_next;
            phase_next  = PH_START;
            acc_next    = '0;
            left_next   = '0;
            inv_next    = 1'b0;
        end
    end

    assign push      = accept && (bnd.nchars != 2'd0 || bnd.has_end);
    assign push_data = bnd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            acc_reg   <= '0;
            left_reg  <= '0;
            inv_reg   <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            left_reg  <= left_next;
            inv_reg   <= inv_next;
        end
    end

endmodule

>>> sv/sled_queue.sv
// short bundle queue between the front end and the result sequencer
module sled_queue
    import sled_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  bundle_t push_data,
    output logic    full,
    input  logic    pop,
    output bundle_t head,
    output logic    empty
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    bundle_t         store_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;

    assign full  = count_reg == CW'(QUEUE_DEPTH);
    assign empty = count_reg == '0;
    assign head  = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> sv/sled_back.sv
// back end: steps through the results of the head bundle
module sled_back
    import sled_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  bundle_t               head,
    input  logic                  empty,
    output logic                  pop,
    output logic                  result_valid,
    input  logic                  result_stall,
    output logic [1:0]            result_kind,
    output logic [CHAR_WIDTH-1:0] char_value,
    output logic                  run_last
);

    logic [1:0] sub_reg, sub_next;
    logic [1:0] total;
    logic       fire;

    assign total        = head.nchars + {1'b0, head.has_end};
    assign result_valid = !empty;
    assign run_last     = sub_reg == total - 2'd1;
    assign fire         = result_valid && !result_stall;
    assign pop          = fire && run_last;

    always_comb
    begin
        if (sub_reg < head.nchars)
        begin
            result_kind = KIND_CHAR;
            char_value  = (sub_reg == 2'd0) ? head.ch0 : head.ch1;
        end
        else
        begin
            result_kind = head.end_bad ? KIND_BAD : KIND_OK;
            char_value  = '0;
        end
    end

    always_comb
    begin
        sub_next = sub_reg;
        if (pop)
        begin
            sub_next = '0;
        end
        else if (fire)
        begin
            sub_next = sub_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sub_reg <= '0;
        end
        else
        begin
            sub_reg <= sub_next;
        end
    end

endmodule

>>> sv/string_literal_escape_decoder_core.sv
// top level of the string literal escape decoder
//
//  channel  | direction | handshake                  | payload
//  item     | in        | item_valid / item_stall     | code_point, token_end
//  result   | out       | result_valid / result_stall | result_kind, char_value, run_last
//
// the front end takes one code point per cycle while the bundle queue has room
// each item yields zero to three results; the back end gives one per cycle unless stalled
// so an item with several results holds its queue entry until the last one is taken
// an item's results enter the queue when it is taken and follow all earlier results
// reset clears decoder state and empties the queue; result_stall only backs up the queue
module string_literal_escape_decoder_core
    import sled_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  logic [CP_WIDTH-1:0]   code_point,
    input  logic                  token_end,
    output logic                  result_valid,
    input  logic                  result_stall,
    output logic [1:0]            result_kind,
    output logic [CHAR_WIDTH-1:0] char_value,
    output logic                  run_last
);

    logic    push;
    bundle_t push_data;
    logic    full;
    logic    pop;
    bundle_t head;
    logic    empty;

    sled_front #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .code_point(code_point),
        .token_end (token_end),
        .queue_full(full),
        .push      (push),
        .push_data (push_data)
    );

    sled_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_data(push_data),
        .full     (full),
        .pop      (pop),
        .head     (head),
        .empty    (empty)
    );

    sled_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .empty       (empty),
        .pop         (pop),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result_kind (result_kind),
        .char_value  (char_value),
        .run_last    (run_last)
    );

endmodule

>>> sv/sled_checker.sv
// port checker for the string literal escape decoder, bound to the top level
module sled_checker
    import sled_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  item_valid,
    input logic                  item_stall,
    input logic                  token_end,
    input logic                  result_valid,
    input logic                  result_stall,
    input logic [1:0]            result_kind,
    input logic [CHAR_WIDTH-1:0] char_value,
    input logic                  run_last
);

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result valid dropped while stalled");

    a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=>
            $stable(result_kind) && $stable(char_value) && $stable(run_last))
        else $error("result payload changed while stalled");

    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_kind != KIND_CHAR |-> run_last && char_value == '0)
        else $error("end result not last of its transfer group");

    a_stall_means_backlog: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> result_valid)
        else $error("input stalled with no result pending");

    a_end_token_done: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && token_end |=> result_valid)
        else $error("token end produced no result");

endmodule

bind string_literal_escape_decoder_core sled_checker u_sled_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .token_end   (token_end),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result_kind (result_kind),
    .char_value  (char_value),
    .run_last    (run_last)
);

>>> test/tb_string_literal_escape_decoder_core.sv
`timescale 1ns / 100ps
// testbench of the string literal escape decoder core: directed plan, random tokens, scoreboard
module tb_string_literal_escape_decoder_core
    import sled_pkg::*;
();

    localparam int LIMIT_CYCLES = 200000;
    localparam int TOTAL_ITEMS  = 220;
    localparam int CALM_ITEMS   = 185;

    localparam logic [CP_WIDTH-1:0] CH_QUOTE  = "\"";
    localparam logic [CP_WIDTH-1:0] CH_BSLASH = "\\";
    localparam logic [CP_WIDTH-1:0] CH_CR     = "\r";
    localparam logic [CP_WIDTH-1:0] CH_LF     = "\n";
    localparam logic [CP_WIDTH-1:0] CH_ZERO   = "0";
    localparam logic [CP_WIDTH-1:0] CH_SEVEN  = "7";
    localparam logic [CP_WIDTH-1:0] CH_NINE   = "9";
    localparam logic [CP_WIDTH-1:0] CH_LA     = "a";
    localparam logic [CP_WIDTH-1:0] CH_LF_HEX = "f";
    localparam logic [CP_WIDTH-1:0] CH_UA     = "A";
    localparam logic [CP_WIDTH-1:0] CH_UF     = "F";
    localparam logic [CP_WIDTH-1:0] CP_TOP    = '1;

    typedef enum logic [3:0] {
        S_OPEN,
        S_TEXT,
        S_ESCAPE,
        S_HEX,
        S_DEC,
        S_OCT,
        S_UNI,
        S_CLOSED
    } lex_state_t;

    typedef struct packed {
        logic [1:0]            kind;
        logic [CHAR_WIDTH-1:0] value;
        logic                  last;
    } decoded_t;

    typedef struct packed {
        logic [CP_WIDTH-1:0]   cp;
        logic                  te;
        logic                  typed;
        logic [1:0]            kind;
        logic [CHAR_WIDTH-1:0] value;
    } plan_row_t;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  item_valid   = 1'b0;
    logic                  item_stall;
    logic [CP_WIDTH-1:0]   code_point   = '0;
    logic                  token_end    = 1'b0;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    logic [1:0]            result_kind;
    logic [CHAR_WIDTH-1:0] char_value;
    logic                  run_last;

    logic                  row_typed = 1'b0;
    logic [1:0]            row_kind  = KIND_CHAR;
    logic [CHAR_WIDTH-1:0] row_value = '0;

    lex_state_t            lex_state   = S_OPEN;
    logic [CHAR_WIDTH-1:0] acc         = '0;
    logic [3:0]            digits_left = '0;
    logic                  bad_seen    = 1'b0;
    decoded_t              step_res [3];
    int                    step_n;
    decoded_t              pending_q [$];

    logic [CP_WIDTH-1:0]   tok_q [$];
    int                    sent_items   = 0;
    int                    idle_pct     = 0;
    bit                    quiet        = 1'b0;
    int                    stall_left   = 0;
    int                    fails        = 0;
    int                    cycles       = 0;

    plan_row_t plan [26] = '{
        '{CH_QUOTE,  1'b0, 1'b0, KIND_CHAR, 32'h0},
        '{"a",       1'b0, 1'b1, KIND_CHAR, 32'h61},
        '{CH_BSLASH, 1'b0, 1'b0, KIND_CHAR, 32'h0},
        '{"n",       1'b0, 1'b1, KIND_CHAR, 32'h0a},
        '{CH_QUOTE,  1'b1, 1'b1, KIND_OK,   32'h0},
        '{CH_BSLASH, 1'b0, 1'b0, KIND_CHAR, 32'h0},
        '{"X",       1'b0, 1'b0, KIND_CHAR, 32'h0},
        '{"F",       1'b0, 1'b0, KIND_CHAR, 32'h0},
        '{"f",       1'b1, 1'b0, KIND_CHAR, 32'h0},
        '{CP_TOP,    1'b0, 1'b1, KIND_CHAR, 32'h1fffff},
        '{CH_LF,     1'b0, 1'b0, KIND_CHAR, 32'h0},
        '{"z",       1'b1, 1'b1, KIND_BAD,  32'h0},
        '{CH_BSLASH, 1'b0, 1'b0, KIND_CHAR, 32'h0},
        '{"u",       1'b0, 1'b0, KIND_CHAR, 32'h0},
        '{"1",       1'b0, 1'b0, KIND_CHAR, 32'h0},
        '{"g",       1'b1, 1'b1, KIND_BAD,  32'h0},
        '{CH_BSLASH, 1'b0, 1'b0, KIND_CHAR, 32'h0},
        '{"D",       1'b0, 1'b0, KIND_CHAR, 32'h0},
        '{"9",       1'b0, 1'b0, KIND_CHAR, 32'h0},
        '{"q",       1'b1, 1'b0, KIND_CHAR, 32'h0},
        '{CH_BSLASH, 1'b0, 1'b0, KIND_CHAR, 32'h0},
        '{"7",       1'b0, 1'b0, KIND_CHAR, 32'h0},
        '{"7",       1'b0, 1'b0, KIND_CHAR, 32'h0},
        '{CH_BSLASH, 1'b1, 1'b0, KIND_CHAR, 32'h0},
        '{CH_BSLASH, 1'b1, 1'b0, KIND_CHAR, 32'h0},
        '{CH_ZERO,   1'b1, 1'b0, KIND_CHAR, 32'h0}
    };

    string_literal_escape_decoder_core i_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .code_point   (code_point),
        .token_end    (token_end),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_kind  (result_kind),
        .char_value   (char_value),
        .run_last     (run_last)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic bit hex_digit(input logic [CP_WIDTH-1:0] c, output logic [3:0] d);
        d = '0;
        if (c >= CH_ZERO && c <= CH_NINE)
        begin
            d = 4'(c - CH_ZERO);
            return 1'b1;
        end
        if (c >= CH_UA && c <= CH_UF)
        begin
            d = 4'(c - CH_UA + 10);
            return 1'b1;
        end
        if (c >= CH_LA && c <= CH_LF_HEX)
        begin
            d = 4'(c - CH_LA + 10);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function void push_decoded(input logic [1:0] kind, input logic [CHAR_WIDTH-1:0] value);
        if (step_n < 3)
        begin
            step_res[step_n] = decoded_t'{kind, value, 1'b0};
            step_n++;
        end
    endfunction

    function void text_char(input logic [CP_WIDTH-1:0] c);
        if (c == CH_QUOTE)
            lex_state = S_CLOSED;
        else if (c == CH_CR || c == CH_LF)
        begin
            bad_seen  = 1'b1;
            lex_state = S_CLOSED;
        end
        else if (c == CH_BSLASH)
            lex_state = S_ESCAPE;
        else
            push_decoded(KIND_CHAR, CHAR_WIDTH'(c));
    endfunction

    function void escape_char(input logic [CP_WIDTH-1:0] c);
        logic [CHAR_WIDTH-1:0] v;
        v   = CHAR_WIDTH'(c);
        acc = '0;
        if (c == "x" || c == "X")
            lex_state = S_HEX;
        else if (c == "d" || c == "D")
            lex_state = S_DEC;
        else if (c >= CH_ZERO && c <= CH_SEVEN)
        begin
            acc       = CHAR_WIDTH'(c - CH_ZERO);
            lex_state = S_OCT;
        end
        else if (c == "u")
        begin
            digits_left = 4'd4;
            lex_state   = S_UNI;
        end
        else if (c == "U")
        begin
            digits_left = 4'd8;
            lex_state   = S_UNI;
        end
        else
        begin
            case (c)
                "a": v = 32'd7;
                "b": v = 32'd8;
                "f": v = 32'd12;
                "n": v = 32'd10;
                "r": v = 32'd13;
                "t": v = 32'd9;
                "v": v = 32'd11;
                default: v = CHAR_WIDTH'(c);
            endcase
            push_decoded(KIND_CHAR, v);
            lex_state = S_TEXT;
        end
    endfunction

    function void close_run(input logic [CP_WIDTH-1:0] c);
        push_decoded(KIND_CHAR, acc);
        acc       = '0;
        lex_state = S_TEXT;
        text_char(c);
    endfunction

    function void decode_step(input logic [CP_WIDTH-1:0] c, input logic te);
        logic [3:0] d;
        step_n = 0;
        case (lex_state)
            S_TEXT:   text_char(c);
            S_ESCAPE: escape_char(c);
            S_HEX:
                if (hex_digit(c, d))
                    acc = CHAR_WIDTH'(acc * 16) + CHAR_WIDTH'(d);
                else
                    close_run(c);
            S_DEC:
                if (c >= CH_ZERO && c <= CH_NINE)
                    acc = CHAR_WIDTH'(acc * 10) + CHAR_WIDTH'(c - CH_ZERO);
                else
                    close_run(c);
            S_OCT:
                if (c >= CH_ZERO && c <= CH_SEVEN)
                    acc = CHAR_WIDTH'(acc * 8) + CHAR_WIDTH'(c - CH_ZERO);
                else
                    close_run(c);
            S_UNI:
            begin
                if (hex_digit(c, d))
                    acc = CHAR_WIDTH'(acc * 16) + CHAR_WIDTH'(d);
                digits_left = digits_left - 4'd1;
                if (digits_left == 4'd0)
                begin
                    push_decoded(KIND_CHAR, acc);
                    acc       = '0;
                    lex_state = S_TEXT;
                end
            end
            S_CLOSED: bad_seen = 1'b1;
            default:
            begin
                lex_state = S_TEXT;
                if (c != CH_QUOTE)
                    text_char(c);
            end
        endcase
        if (te)
        begin
            if (lex_state == S_ESCAPE)
                push_decoded(KIND_CHAR, '0);
            else if (lex_state == S_HEX || lex_state == S_DEC || lex_state == S_OCT)
                push_decoded(KIND_CHAR, acc);
            else if (lex_state == S_UNI && digits_left != 4'd0)
                bad_seen = 1'b1;
            push_decoded(bad_seen ? KIND_BAD : KIND_OK, '0);
            lex_state   = S_OPEN;
            acc         = '0;
            digits_left = '0;
            bad_seen    = 1'b0;
        end
        if (step_n > 0)
            step_res[step_n-1].last = 1'b1;
    endfunction

    function void check_result();
        decoded_t want;
        if (pending_q.size() == 0)
        begin
            $error("unexpected transfer kind %0d value %0h", result_kind, char_value);
            fails++;
            return;
        end
        want = pending_q.pop_front();
        if (result_kind !== want.kind)
        begin
            $error("result_kind expected %0d actual %0d", want.kind, result_kind);
            fails++;
        end
        if (char_value !== want.value)
        begin
            $error("char_value expected %0h actual %0h", want.value, char_value);
            fails++;
        end
        if (run_last !== want.last)
        begin
            $error("run_last expected %0d actual %0d", want.last, run_last);
            fails++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
                check_result();
            if (item_valid && !item_stall)
            begin
                decode_step(code_point, token_end);
                if (row_typed)
                    pending_q.push_back(decoded_t'{row_kind, row_value, 1'b1});
                else
                    for (int k = 0; k < step_n; k++)
                        pending_q.push_back(step_res[k]);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == LIMIT_CYCLES)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n || quiet)
        begin
            stall_left = 0;
            result_stall <= 1'b0;
        end
        else if (stall_left != 0)
        begin
            stall_left--;
            result_stall <= 1'b1;
        end
        else if ($urandom_range(0, 99) < idle_pct)
        begin
            stall_left = $urandom_range(0, 7);
            result_stall <= 1'b1;
        end
        else
            result_stall <= 1'b0;
    end

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_item(input logic [CP_WIDTH-1:0] cp, input logic te, input logic typed,
                             input logic [1:0] kind, input logic [CHAR_WIDTH-1:0] value);
        if (!quiet && $urandom_range(0, 99) < idle_pct)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        item_valid <= 1'b1;
        code_point <= cp;
        token_end  <= te;
        row_typed  <= typed;
        row_kind   <= kind;
        row_value  <= value;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        sent_items++;
        @(negedge clk);
    endtask

    function automatic logic [CP_WIDTH-1:0] rand_hex();
        int v;
        v = $urandom_range(0, 15);
        if (v < 10)
            return CP_WIDTH'(CH_ZERO + v);
        return CP_WIDTH'(($urandom_range(0, 1) ? CH_LA : CH_UA) + v - 10);
    endfunction

    function automatic logic [CP_WIDTH-1:0] rand_wide();
        return CP_WIDTH'($urandom_range(0, 21'h1fffff));
    endfunction

    task automatic gen_token();
        int    pieces;
        int    n;
        string esc_set;
        esc_set = "abfnrtv'?ezq\"\\";
        tok_q.delete();
        if ($urandom_range(0, 4) != 0)
            tok_q.push_back(CH_QUOTE);
        pieces = $urandom_range(0, 5);
        for (int p = 0; p < pieces; p++)
        begin
            case ($urandom_range(0, 12))
                0, 1, 2:
                    tok_q.push_back(CP_WIDTH'($urandom_range("#", "[")));
                3:
                    tok_q.push_back(rand_wide());
                4:
                begin
                    tok_q.push_back(CH_BSLASH);
                    tok_q.push_back(CP_WIDTH'($urandom_range(0, 1) ? "x" : "X"));
                    n = $urandom_range(0, 10);
                    repeat (n) tok_q.push_back(rand_hex());
                end
                5:
                begin
                    tok_q.push_back(CH_BSLASH);
                    tok_q.push_back(CP_WIDTH'($urandom_range(0, 1) ? "d" : "D"));
                    n = $urandom_range(0, 12);
                    repeat (n) tok_q.push_back(CP_WIDTH'(CH_ZERO + $urandom_range(0, 9)));
                end
                6:
                begin
                    tok_q.push_back(CH_BSLASH);
                    n = $urandom_range(0, 12);
                    repeat (n + 1) tok_q.push_back(CP_WIDTH'(CH_ZERO + $urandom_range(0, 7)));
                end
                7, 8:
                begin
                    tok_q.push_back(CH_BSLASH);
                    tok_q.push_back(CP_WIDTH'($urandom_range(0, 1) ? "u" : "U"));
                    n = (tok_q[$] == "u") ? 4 : 8;
                    repeat (n) tok_q.push_back($urandom_range(0, 5) == 0 ? rand_wide()
                                                                        : rand_hex());
                end
                9, 10:
                begin
                    tok_q.push_back(CH_BSLASH);
                    if ($urandom_range(0, 5) == 0)
                        tok_q.push_back($urandom_range(0, 1) ? CH_CR : CH_LF);
                    else
                        tok_q.push_back(CP_WIDTH'(esc_set[$urandom_range(0, esc_set.len()-1)]));
                end
                11:
                    if ($urandom_range(0, 2) == 0)
                        tok_q.push_back($urandom_range(0, 1) ? CH_CR : CH_LF);
                    else
                        tok_q.push_back(CP_WIDTH'($urandom_range("a", "z")));
                default:
                begin
                    tok_q.push_back(CH_QUOTE);
                    n = $urandom_range(0, 2);
                    repeat (n) tok_q.push_back(rand_wide());
                end
            endcase
        end
        // unfinished escapes, or a closing quote, at the end of the token
        case ($urandom_range(0, 7))
            0:
                tok_q.push_back(CH_BSLASH);
            1:
            begin
                tok_q.push_back(CH_BSLASH);
                tok_q.push_back(CP_WIDTH'("u"));
                repeat ($urandom_range(0, 3)) tok_q.push_back(rand_hex());
            end
            2:
            begin
                tok_q.push_back(CH_BSLASH);
                tok_q.push_back(CP_WIDTH'("U"));
                repeat ($urandom_range(0, 7)) tok_q.push_back(rand_hex());
            end
            3, 4:
                tok_q.push_back(CH_QUOTE);
            default:
                if (tok_q.size() == 0)
                    tok_q.push_back(CH_QUOTE);
        endcase
        foreach (tok_q[i])
            send_item(tok_q[i], i == tok_q.size() - 1, 1'b0, KIND_CHAR, '0);
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        idle_pct = 20;
        foreach (plan[i])
            send_item(plan[i].cp, plan[i].te, plan[i].typed, plan[i].kind, plan[i].value);
        while (sent_items < TOTAL_ITEMS)
        begin
            quiet = (sent_items >= CALM_ITEMS);
            case ($urandom_range(0, 2))
                0: idle_pct = 0;
                1: idle_pct = 10;
                default: idle_pct = 35;
            endcase
            if (quiet)
                idle_pct = 0;
            gen_token();
        end
        item_valid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fails == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
